// File: hdl/rms_emittance_accumulator_macros.svh
// assertion macros shared by the checker of the rms emittance accumulator
// depends on nothing; included by the checker file
`ifndef RMS_EMITTANCE_ACCUMULATOR_MACROS_SVH
`define RMS_EMITTANCE_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rms emittance check failed");

// next-cycle implication, disabled during reset
`define RMSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rms emittance check failed");

`endif

// File: hdl/rmse_pkg.sv
// types, constants and helper functions of the rms emittance accumulator
// depends on nothing
`default_nettype none

package rmse_pkg;

  localparam int FRAC          = 20;
  localparam int MAX_PARTICLES = 1048576;
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int NSUM          = 15;
  localparam int NTERM         = 5;
  localparam int NAXIS         = 3;
  localparam int SUM_IDX_W     = $clog2(NSUM);

  // per-axis moment terms, also the index of the matching mean
  localparam logic [2:0] TERM_Q  = 3'd0;
  localparam logic [2:0] TERM_QQ = 3'd1;
  localparam logic [2:0] TERM_V  = 3'd2;
  localparam logic [2:0] TERM_VV = 3'd3;
  localparam logic [2:0] TERM_QV = 3'd4;

  // final multiply steps
  localparam logic [2:0] FM_QQ  = 3'd0;
  localparam logic [2:0] FM_VV  = 3'd1;
  localparam logic [2:0] FM_QV  = 3'd2;
  localparam logic [2:0] FM_DET = 3'd3;
  localparam logic [2:0] FM_CC  = 3'd4;

  // final root steps
  localparam logic [2:0] SQ_SIG = 3'd0;
  localparam logic [2:0] SQ_EMI = 3'd1;

  localparam logic [1:0] LAST_AXIS = 2'(NAXIS - 1);

  localparam logic [63:0] G2_INIT = 64'd1 << (2 * FRAC);
  localparam logic [63:0] SQ_LIM  = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC;
  localparam logic [63:0] C_LIM   = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic               is_lost;
    logic               last_item;
  } rmse_in_t;

  typedef struct packed {
    logic [20:0]        alive_count;
    logic [20:0]        total_count;
    logic signed [31:0] mean_z;
    logic [30:0]        sigma_x;
    logic [30:0]        emit_x;
    logic [30:0]        sigma_y;
    logic [30:0]        emit_y;
    logic [30:0]        sigma_z;
    logic [30:0]        emit_z;
    logic               none_alive;
  } rmse_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GMUL,
    S_GWAIT,
    S_GSQRT,
    S_GSWAIT,
    S_VDIV,
    S_VWAIT,
    S_TERM,
    S_TWAIT,
    S_END,
    S_FDIV,
    S_FDWAIT,
    S_FMUL,
    S_FMWAIT,
    S_FSQ,
    S_FSWAIT,
    S_DONE
  } rmse_state_e;

  function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [63:0] clamp_mean(input logic [2:0] k,
                                                    input logic signed [63:0] v);
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    lo = 64'sd0;
    hi = 64'sd0;
    unique case (k)
      TERM_Q: begin
        lo = -(64'sd1 <<< 31);
        hi = (64'sd1 <<< 31) - 64'sd1;
      end
      TERM_QQ: begin
        lo = 64'sd0;
        hi = 64'sd1 <<< (62 - FRAC);
      end
      TERM_V: begin
        lo = -(64'sd1 <<< FRAC);
        hi = 64'sd1 <<< FRAC;
      end
      TERM_VV: begin
        lo = 64'sd0;
        hi = 64'sd1 <<< FRAC;
      end
      default: begin
        lo = -(64'sd1 <<< 31);
        hi = 64'sd1 <<< 31;
      end
    endcase
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] sqrt_arg(input logic [63:0] m);
    return ((m > SQ_LIM) ? SQ_LIM : m) << FRAC;
  endfunction

  function automatic logic [30:0] sat31(input logic [31:0] r);
    return r[31] ? {31{1'b1}} : r[30:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/rmse_mul.sv
// shared 64 by 32 bit unsigned multiplier, two 32x32 partial products
// depends on rmse_pkg
`default_nettype none

module rmse_mul
  import rmse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q;
  logic [31:0] b_q;
  logic [63:0] acc_q;
  logic        busy_q;
  logic        hi_q;
  logic        done_q;
  logic [63:0] part;

  assign part = (hi_q ? a_q[63:32] : a_q[31:0]) * b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hi_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      hi_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (!hi_q) begin
        hi_q <= 1'b1;
      end else begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (!hi_q) begin
        acc_q <= part;
      end else begin
        acc_q <= acc_q + {part[31:0], 32'd0};
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

// File: hdl/rmse_div.sv
// iterative unsigned divider, 64 bit dividend by 32 bit divisor, two bits a cycle
// depends on rmse_pkg
`default_nettype none

module rmse_div
  import rmse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [32:0] r1, r2, s1, s2;
  logic        ge1, ge2;
  logic [63:0] q1, q2;

  always_comb begin
    r1  = {rem_q, quo_q[63]};
    ge1 = r1 >= {1'b0, den_q};
    s1  = ge1 ? (r1 - {1'b0, den_q}) : r1;
    q1  = {quo_q[62:0], ge1};
    r2  = {s1[31:0], q1[63]};
    ge2 = r2 >= {1'b0, den_q};
    s2  = ge2 ? (r2 - {1'b0, den_q}) : r2;
    q2  = {q1[62:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= q2;
      rem_q <= s2[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: hdl/rmse_isqrt.sv
// iterative floor square root of a 64 bit word, one root bit a cycle
// depends on rmse_pkg
`default_nettype none

module rmse_isqrt
  import rmse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [34:0] shifted;
  logic [34:0] trial;
  logic        ge;

  always_comb begin
    shifted = {rem_q[32:0], rad_q[63:62]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? (shifted - trial) : shifted;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: hdl/rms_emittance_accumulator.sv
// a lost or surplus particle goes from S_IDLE to S_END and back; a live one first takes
// three multiplies, a root, three divides and 15 sum steps, nine of them with a multiply
// after the last particle the word is built with 15 divides, 15 multiplies and 6 roots,
// or with none of these if no particle is alive; one word in flight
// asynchronous active-low reset clears all sums, counters and the output valid
// depends on rmse_pkg, rmse_mul, rmse_div, rmse_isqrt
`default_nettype none

module rms_emittance_accumulator
  import rmse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rmse_in_t  in_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output rmse_out_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  rmse_state_e state_q, state_d;

  logic [1:0]           ax_q;
  logic [2:0]           k_q;
  logic [CNT_W-1:0]     total_q;
  logic [CNT_W-1:0]     alive_q;
  logic signed [63:0]   sums_q [NSUM];
  rmse_in_t             item_q;
  logic [63:0]          g2_q;
  logic [31:0]          gamma_q;
  logic signed [63:0]   v_q;
  logic signed [63:0]   mean_q [NTERM];
  logic signed [63:0]   sqq_q, svv_q, sqv_q, tdet_q, det_q;
  logic [30:0]          sig_q [NAXIS];
  logic [30:0]          emi_q [NAXIS];
  logic signed [31:0]   mz_q;
  rmse_out_t            out_q;
  logic                 out_valid_q;
  logic                 mul_neg_q;
  logic                 div_neg_q;

  logic                 in_acc;
  logic                 counted;
  logic                 out_free;
  logic [SUM_IDX_W-1:0] sum_idx;
  logic signed [63:0]   q_ax, u_ax;
  logic                 term_mul;

  logic                 mul_start, mul_done;
  logic signed [63:0]   mul_x, mul_y;
  logic [31:0]          mul_b;
  logic [63:0]          mul_p;
  logic [63:0]          mul_sh;
  logic signed [63:0]   qmul_val;

  logic                 div_start, div_done, div_neg;
  logic [63:0]          div_num, div_quo;
  logic [31:0]          div_den;
  logic signed [63:0]   div_val;

  logic                 sq_start, sq_done;
  logic [63:0]          sq_rad;
  logic [31:0]          sq_root;

  logic signed [63:0]   c_val;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign counted     = total_q < CNT_W'(MAX_PARTICLES);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sum_idx  = SUM_IDX_W'({2'b00, ax_q} * 4'd5) + SUM_IDX_W'(k_q);
  assign term_mul = (k_q == TERM_QQ) || (k_q == TERM_VV) || (k_q == TERM_QV);

  always_comb begin
    unique case (ax_q)
      2'd0: begin
        q_ax = sext32(item_q.pos_x);
        u_ax = sext32(item_q.mom_x);
      end
      2'd1: begin
        q_ax = sext32(item_q.pos_y);
        u_ax = sext32(item_q.mom_y);
      end
      default: begin
        q_ax = sext32(item_q.pos_z);
        u_ax = sext32(item_q.mom_z);
      end
    endcase
  end

  assign mul_sh   = mul_p >> FRAC;
  assign qmul_val = mul_neg_q ? -$signed(mul_sh) : $signed(mul_sh);
  assign div_val  = div_neg_q ? -$signed(div_quo) : $signed(div_quo);
  assign c_val    = (mag64(sqv_q) > C_LIM) ? $signed(C_LIM) : $signed(mag64(sqv_q));
  assign mul_b    = 32'(mag64(mul_y));

  rmse_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag64(mul_x)),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  rmse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  rmse_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (counted && !in_data_i.is_lost) ? S_GMUL : S_END;
        end
      end
      S_GMUL:   state_d = S_GWAIT;
      S_GWAIT: begin
        if (mul_done) begin
          state_d = (ax_q == LAST_AXIS) ? S_GSQRT : S_GMUL;
        end
      end
      S_GSQRT:  state_d = S_GSWAIT;
      S_GSWAIT: if (sq_done) state_d = S_VDIV;
      S_VDIV:   state_d = S_VWAIT;
      S_VWAIT:  if (div_done) state_d = S_TERM;
      S_TERM: begin
        if (term_mul) begin
          state_d = S_TWAIT;
        end else begin
          state_d = S_TERM;
        end
      end
      S_TWAIT: begin
        if (mul_done) begin
          if (k_q == TERM_QV) begin
            state_d = (ax_q == LAST_AXIS) ? S_END : S_VDIV;
          end else begin
            state_d = S_TERM;
          end
        end
      end
      S_END: begin
        if (item_q.last_item) begin
          state_d = (alive_q == '0) ? S_DONE : S_FDIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FDIV:   state_d = S_FDWAIT;
      S_FDWAIT: if (div_done) state_d = (k_q == TERM_QV) ? S_FMUL : S_FDIV;
      S_FMUL:   state_d = S_FMWAIT;
      S_FMWAIT: if (mul_done) state_d = (k_q == FM_CC) ? S_FSQ : S_FMUL;
      S_FSQ:    state_d = S_FSWAIT;
      S_FSWAIT: begin
        if (sq_done) begin
          if (k_q == SQ_EMI) begin
            state_d = (ax_q == LAST_AXIS) ? S_DONE : S_FDIV;
          end else begin
            state_d = S_FSQ;
          end
        end
      end
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // unit controls and operands
  always_comb begin
    mul_start = 1'b0;
    mul_x     = '0;
    mul_y     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    unique case (state_q)
      S_GMUL: begin
        mul_start = 1'b1;
        mul_x     = u_ax;
        mul_y     = u_ax;
      end
      S_GSQRT: begin
        sq_start = 1'b1;
        sq_rad   = g2_q;
      end
      S_VDIV: begin
        div_start = 1'b1;
        div_num   = mag64(u_ax) << FRAC;
        div_den   = gamma_q;
        div_neg   = u_ax[63];
      end
      S_TERM: begin
        mul_start = term_mul;
        priority case (k_q)
          TERM_QQ: begin
            mul_x = q_ax;
            mul_y = q_ax;
          end
          TERM_VV: begin
            mul_x = v_q;
            mul_y = v_q;
          end
          default: begin
            mul_x = q_ax;
            mul_y = v_q;
          end
        endcase
      end
      S_FDIV: begin
        div_start = 1'b1;
        div_num   = mag64(sums_q[sum_idx]);
        div_den   = 32'(alive_q);
        div_neg   = sums_q[sum_idx][63];
      end
      S_FMUL: begin
        mul_start = 1'b1;
        priority case (k_q)
          FM_QQ: begin
            mul_x = mean_q[TERM_Q];
            mul_y = mean_q[TERM_Q];
          end
          FM_VV: begin
            mul_x = mean_q[TERM_V];
            mul_y = mean_q[TERM_V];
          end
          FM_QV: begin
            mul_x = mean_q[TERM_Q];
            mul_y = mean_q[TERM_V];
          end
          FM_DET: begin
            mul_x = sqq_q;
            mul_y = svv_q;
          end
          default: begin
            mul_x = c_val;
            mul_y = c_val;
          end
        endcase
      end
      S_FSQ: begin
        sq_start = 1'b1;
        sq_rad   = (k_q == SQ_SIG) ? sqrt_arg(mag64(sqq_q)) : sqrt_arg(mag64(det_q));
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // control state, counters and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      k_q         <= '0;
      total_q     <= '0;
      alive_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NSUM; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          ax_q <= '0;
          k_q  <= '0;
          if (in_acc && counted) begin
            total_q <= total_q + CNT_W'(1);
            if (!in_data_i.is_lost) begin
              alive_q <= alive_q + CNT_W'(1);
            end
          end
        end
        S_GWAIT: begin
          if (mul_done) begin
            ax_q <= (ax_q == LAST_AXIS) ? 2'd0 : ax_q + 2'd1;
          end
        end
        S_VWAIT: begin
          if (div_done) begin
            k_q <= '0;
          end
        end
        S_TERM: begin
          if (!term_mul) begin
            sums_q[sum_idx] <= sat_add(sums_q[sum_idx], (k_q == TERM_Q) ? q_ax : v_q);
            k_q <= k_q + 3'd1;
          end
        end
        S_TWAIT: begin
          if (mul_done) begin
            sums_q[sum_idx] <= sat_add(sums_q[sum_idx], qmul_val);
            if (k_q == TERM_QV) begin
              k_q  <= '0;
              ax_q <= (ax_q == LAST_AXIS) ? 2'd0 : ax_q + 2'd1;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        S_END: begin
          ax_q <= '0;
          k_q  <= '0;
        end
        S_FDWAIT: begin
          if (div_done) begin
            k_q <= (k_q == TERM_QV) ? 3'd0 : k_q + 3'd1;
          end
        end
        S_FMWAIT: begin
          if (mul_done) begin
            k_q <= (k_q == FM_CC) ? 3'd0 : k_q + 3'd1;
          end
        end
        S_FSWAIT: begin
          if (sq_done) begin
            if (k_q == SQ_EMI) begin
              k_q  <= '0;
              ax_q <= (ax_q == LAST_AXIS) ? 2'd0 : ax_q + 2'd1;
            end else begin
              k_q <= SQ_EMI;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            total_q     <= '0;
            alive_q     <= '0;
            for (int i = 0; i < NSUM; i++) begin
              sums_q[i] <= '0;
            end
          end
        end
        default: begin
          ax_q <= ax_q;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mul_neg_q <= mul_x[63] ^ mul_y[63];
    end
    if (div_start) begin
      div_neg_q <= div_neg;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_q <= in_data_i;
          g2_q   <= G2_INIT;
        end
      end
      S_GWAIT:  if (mul_done) g2_q <= g2_q + mul_p;
      S_GSWAIT: if (sq_done) gamma_q <= sq_root;
      S_VWAIT:  if (div_done) v_q <= div_val;
      S_FDWAIT: if (div_done) mean_q[k_q] <= clamp_mean(k_q, div_val);
      S_FMWAIT: begin
        if (mul_done) begin
          priority case (k_q)
            FM_QQ:   sqq_q  <= mean_q[TERM_QQ] - qmul_val;
            FM_VV:   svv_q  <= mean_q[TERM_VV] - qmul_val;
            FM_QV:   sqv_q  <= mean_q[TERM_QV] - qmul_val;
            FM_DET:  tdet_q <= qmul_val;
            default: det_q  <= tdet_q - $signed(mul_sh);
          endcase
        end
      end
      S_FSWAIT: begin
        if (sq_done) begin
          if (k_q == SQ_SIG) begin
            sig_q[ax_q] <= sat31(sq_root);
          end else begin
            emi_q[ax_q] <= sat31(sq_root);
          end
          if (ax_q == LAST_AXIS) begin
            mz_q <= mean_q[TERM_Q][31:0];
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (alive_q == '0) begin
            out_q <= '{none_alive: 1'b1, default: '0};
          end else begin
            out_q.alive_count <= 21'(alive_q);
            out_q.total_count <= 21'(total_q);
            out_q.mean_z      <= mz_q;
            out_q.sigma_x     <= sig_q[0];
            out_q.emit_x      <= emi_q[0];
            out_q.sigma_y     <= sig_q[1];
            out_q.emit_y      <= emi_q[1];
            out_q.sigma_z     <= sig_q[2];
            out_q.emit_z      <= emi_q[2];
            out_q.none_alive  <= 1'b0;
          end
        end
      end
      default: begin
        item_q <= item_q;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/rmse_checker.sv
// port-level checks of the rms emittance accumulator, bound to the top level
// depends on rmse_pkg and rms_emittance_accumulator_macros.svh
`default_nettype none

`include "rms_emittance_accumulator_macros.svh"

module rmse_checker
  import rmse_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input rmse_in_t  in_data_i,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input rmse_out_t out_data_o,
  input logic      out_valid_o,
  input logic      out_stall_i
);

  logic in_acc;
  logic empty_zero;
  logic count_ok;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign empty_zero = (out_data_o.alive_count == 21'd0) && (out_data_o.total_count == 21'd0)
                      && (out_data_o.mean_z == 32'sd0) && (out_data_o.sigma_x == 31'd0)
                      && (out_data_o.emit_z == 31'd0);
  assign count_ok   = (out_data_o.alive_count != 21'd0)
                      && (out_data_o.alive_count <= out_data_o.total_count);

  // a taken word makes the block busy in the next cycle
  `RMSE_ASSERT_NXT(busy_after_take, clk_i, rst_ni, in_acc, in_stall_o)

  // an empty set reports the flag with zero counts, mean_z, sigma_x and emit_z
  `RMSE_ASSERT_IMP(empty_set_zero, clk_i, rst_ni, out_valid_o && out_data_o.none_alive, empty_zero)

  // a non-empty set has live particles, never more than it has seen
  `RMSE_ASSERT_IMP(count_order, clk_i, rst_ni, out_valid_o && !out_data_o.none_alive, count_ok)

  // a stalled result word stays offered
  `RMSE_ASSERT_NXT(out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind rms_emittance_accumulator rmse_checker u_rmse_checker (.*);

`default_nettype wire

// File: test/tb_rms_emittance_accumulator.sv
// testbench of the rms emittance accumulator: directed and random particle sets,
// predicted word by word with a behavioral moment model and compared as whole words
// depends on rmse_pkg and rms_emittance_accumulator
`timescale 1ns / 100ps

module tb_rms_emittance_accumulator;
  import rmse_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  rmse_in_t  in_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  rmse_out_t out_data_o;
  logic      out_valid_o;
  logic      out_stall_i;

  rms_emittance_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  localparam longint ONE = 64'sd1 << FRAC;

  longint    beam_sums [15];
  int        alive_n;
  int        total_n;
  rmse_out_t expected_words [$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sum_sat(longint a, longint b);
    longint s;
    s = a + b;
    if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) s = (b < 0) ? 64'sh8000000000000000
                                                             : 64'sh7fffffffffffffff;
    return s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) / ONE;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic logic [30:0] root_q(longint unsigned m);
    longint unsigned r;
    if (m > (64'hffffffffffffffff >> FRAC)) m = 64'hffffffffffffffff >> FRAC;
    r = int_sqrt(m << FRAC);
    return r > 64'h7fffffff ? 31'h7fffffff : r[30:0];
  endfunction

  task automatic clear_beam();
    for (int k = 0; k < 15; k++) beam_sums[k] = 0;
    alive_n = 0;
    total_n = 0;
  endtask

  task automatic predict_particle(rmse_in_t p);
    longint q [3];
    longint u [3];
    longint v;
    longint unsigned g2;
    longint gam;
    longint n;
    longint qm, q2, vm, v2, qv, sqq, svv, sqv, det;
    longint unsigned c;
    rmse_out_t w;
    if (total_n < MAX_PARTICLES) begin
      total_n++;
      if (!p.is_lost) begin
        alive_n++;
        q = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
        u = '{longint'(p.mom_x), longint'(p.mom_y), longint'(p.mom_z)};
        g2 = 64'd1 << (2 * FRAC);
        for (int a = 0; a < 3; a++) g2 += longint'(u[a] * u[a]);
        gam = int_sqrt(g2);
        for (int a = 0; a < 3; a++) begin
          v = (u[a] * ONE) / gam;
          beam_sums[a*5]   = sum_sat(beam_sums[a*5], q[a]);
          beam_sums[a*5+1] = sum_sat(beam_sums[a*5+1], fx_mul(q[a], q[a]));
          beam_sums[a*5+2] = sum_sat(beam_sums[a*5+2], v);
          beam_sums[a*5+3] = sum_sat(beam_sums[a*5+3], fx_mul(v, v));
          beam_sums[a*5+4] = sum_sat(beam_sums[a*5+4], fx_mul(q[a], v));
        end
      end
    end
    if (!p.last_item) return;
    w = '0;
    if (alive_n == 0) begin
      w.none_alive = 1'b1;
    end else begin
      n = alive_n;
      w.alive_count = alive_n[20:0];
      w.total_count = total_n[20:0];
      for (int a = 0; a < 3; a++) begin
        qm = clip(beam_sums[a*5] / n, -(64'sd1 << 31), (64'sd1 << 31) - 1);
        q2 = clip(beam_sums[a*5+1] / n, 0, 64'sd1 << (62 - FRAC));
        vm = clip(beam_sums[a*5+2] / n, -ONE, ONE);
        v2 = clip(beam_sums[a*5+3] / n, 0, ONE);
        qv = clip(beam_sums[a*5+4] / n, -(64'sd1 << 31), 64'sd1 << 31);
        sqq = q2 - fx_mul(qm, qm);
        svv = v2 - fx_mul(vm, vm);
        sqv = qv - fx_mul(qm, vm);
        c = abs64(sqv);
        if (c > 64'hffffffff) c = 64'hffffffff;
        det = fx_mul(sqq, svv) - longint'((c * c) >> FRAC);
        case (a)
          0: begin
            w.sigma_x = root_q(abs64(sqq));
            w.emit_x  = root_q(abs64(det));
          end
          1: begin
            w.sigma_y = root_q(abs64(sqq));
            w.emit_y  = root_q(abs64(det));
          end
          default: begin
            w.sigma_z = root_q(abs64(sqq));
            w.emit_z  = root_q(abs64(det));
            w.mean_z  = qm[31:0];
          end
        endcase
      end
    end
    expected_words = {expected_words, w};
    clear_beam();
  endtask

  task automatic send_particle(rmse_in_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= p;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_particle(p);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && rst_ni) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data_o);
      end else begin
        if (out_data_o !== expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_words[0], out_data_o);
        end
        void'(expected_words.pop_front());
      end
    end
    out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return $signed($urandom_range(0, 8 << FRAC)) - (32'sd4 << FRAC);
      default: return $signed($urandom_range(0, 1 << 22)) - (32'sd1 << 21);
    endcase
  endfunction

  function automatic rmse_in_t rand_particle(bit last, int lost_pct);
    rmse_in_t p;
    p.pos_x = rand_val();
    p.pos_y = rand_val();
    p.pos_z = rand_val();
    p.mom_x = rand_val();
    p.mom_y = rand_val();
    p.mom_z = rand_val();
    p.is_lost   = $urandom_range(99) < lost_pct;
    p.last_item = last;
    return p;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    rmse_in_t p;
    p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0};
    send_particle(p);
    p = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh80000000, 1'b0, 1'b1};
    send_particle(p);
    p = '0;
    p.last_item = 1'b1;
    send_particle(p);
    p = '1;
    send_particle(p);
    p = '{32'sd1 << FRAC, -(32'sd1 << FRAC), 32'sd5, 32'sd0, 32'sd1 << FRAC,
          32'sd3 << FRAC, 1'b0, 1'b1};
    send_particle(p);
  endtask

  task automatic test_none_alive();
    rmse_in_t p;
    for (int k = 0; k < 4; k++) begin
      p = rand_particle(k == 3, 100);
      send_particle(p);
    end
  endtask

  task automatic test_saturating_sums();
    for (int k = 0; k < 8; k++)
      send_particle('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh80000000, 1'b0, k == 7});
  endtask

  task automatic test_random_sets(int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        send_particle(rand_particle(k == len - 1, $urandom_range(1) ? 20 : 60));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_data_i      = '0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_beam();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_none_alive();
    test_saturating_sums();
    test_random_sets(280);
    wait_drained();
    send_idle_pct = 45;
    test_random_sets(280);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    test_random_sets(280);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    test_random_sets(280);
    wait_drained();
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rmse_pkg.sv
hdl/rmse_mul.sv
hdl/rmse_div.sv
hdl/rmse_isqrt.sv
hdl/rms_emittance_accumulator.sv
hdl/rmse_checker.sv
test/tb_rms_emittance_accumulator.sv
